FILE: hdl/morse_key_decoder_defines.svh
// Assertion macros for the Morse key decoder.
// Included by the top level; needs nothing else.
`ifndef MORSE_KEY_DECODER_DEFINES_SVH
`define MORSE_KEY_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("morse_key_decoder: check failed");

// next-cycle implication, disabled in reset
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("morse_key_decoder: check failed");

`endif

FILE: hdl/mkd_pkg.sv
// Types, constants and the Morse lookup table for the Morse key decoder.
// No dependencies.
package mkd_pkg;

  localparam int MKD_MAX_SYMBOLS = 6;
  localparam int MKD_CODE_W      = 7;

  localparam logic [7:0] MIN_PRESS_RST  = 8'd5;
  localparam logic [7:0] DOT_LIMIT_RST  = 8'd38;
  localparam logic [7:0] DASH_LIMIT_RST = 8'd114;
  localparam logic [7:0] GAP_TICKS_RST  = 8'd152;

  localparam logic [1:0] REG_MIN_PRESS  = 2'd0;
  localparam logic [1:0] REG_DOT_LIMIT  = 2'd1;
  localparam logic [1:0] REG_DASH_LIMIT = 2'd2;
  localparam logic [1:0] REG_GAP_TICKS  = 2'd3;

  localparam logic [1:0] EV_DOT  = 2'd0;
  localparam logic [1:0] EV_DASH = 2'd1;
  localparam logic [1:0] EV_LONG = 2'd2;
  localparam logic [1:0] EV_CHAR = 2'd3;

  localparam logic [6:0] CHAR_SPACE   = 7'h20;
  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;

  typedef struct packed {
    logic key_down;
  } mkd_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] char_code;
    logic       recognized;
    logic       last;
  } mkd_out_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] ascii;
  } mkd_lookup_t;

  function automatic mkd_lookup_t mkd_lookup(input logic [MKD_CODE_W-1:0] code);
    mkd_lookup_t res;
    res = '{hit: 1'b1, ascii: 7'h00};
    case (code)
      7'd2:    res.ascii = 7'h45;
      7'd3:    res.ascii = 7'h54;
      7'd4:    res.ascii = 7'h49;
      7'd5:    res.ascii = 7'h41;
      7'd6:    res.ascii = 7'h4E;
      7'd7:    res.ascii = 7'h4D;
      7'd8:    res.ascii = 7'h53;
      7'd9:    res.ascii = 7'h55;
      7'd10:   res.ascii = 7'h52;
      7'd11:   res.ascii = 7'h57;
      7'd12:   res.ascii = 7'h44;
      7'd13:   res.ascii = 7'h4B;
      7'd14:   res.ascii = 7'h47;
      7'd15:   res.ascii = 7'h4F;
      7'd16:   res.ascii = 7'h48;
      7'd17:   res.ascii = 7'h56;
      7'd18:   res.ascii = 7'h46;
      7'd20:   res.ascii = 7'h4C;
      7'd22:   res.ascii = 7'h50;
      7'd23:   res.ascii = 7'h4A;
      7'd24:   res.ascii = 7'h42;
      7'd25:   res.ascii = 7'h58;
      7'd26:   res.ascii = 7'h43;
      7'd27:   res.ascii = 7'h59;
      7'd28:   res.ascii = 7'h5A;
      7'd29:   res.ascii = 7'h51;
      7'd32:   res.ascii = 7'h35;
      7'd33:   res.ascii = 7'h34;
      7'd35:   res.ascii = 7'h33;
      7'd39:   res.ascii = 7'h32;
      7'd47:   res.ascii = 7'h31;
      7'd48:   res.ascii = 7'h36;
      7'd56:   res.ascii = 7'h37;
      7'd60:   res.ascii = 7'h38;
      7'd62:   res.ascii = 7'h39;
      7'd63:   res.ascii = 7'h30;
      7'd85:   res.ascii = 7'h2E;
      7'd115:  res.ascii = 7'h2C;
      default: res = '{hit: 1'b0, ascii: CHAR_UNKNOWN};
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/mkd_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is set by the instantiating level, usually from mkd_pkg.
interface mkd_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/morse_key_decoder.sv
// Morse key decoder top level: press/silence counters, symbol buffer, decode.
// Depends on mkd_pkg, mkd_chan_if and morse_key_decoder_defines.svh.
//
// One tick item per clock is taken on in_chan while it is ready. Each tick
// yields zero, one or two results on out_chan (dot/dash/long-press events,
// then decoded characters or a space). A two-entry result register holds
// the results of one tick; in_chan stays ready while that register is empty
// or its last entry leaves in the same cycle, so two results from one tick
// stall in_chan until the first has left. Configuration writes take effect
// on the next cycle and are meant to be issued while the block is idle.
`include "morse_key_decoder_defines.svh"

module morse_key_decoder #(
  parameter int MAX_SYMBOLS = mkd_pkg::MKD_MAX_SYMBOLS
) (
  input  logic       clk,
  input  logic       rst_n,
  mkd_chan_if.sink   in_chan,
  mkd_chan_if.source out_chan,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import mkd_pkg::*;

  localparam int TOT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W  = $clog2(MAX_SYMBOLS);
  localparam int CODE_W = MAX_SYMBOLS + 1;

  logic [7:0] min_press_r, dot_limit_r, dash_limit_r, gap_ticks_r;

  logic [7:0]       press_r, press_nxt;
  logic [7:0]       silence_r, silence_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             store_r   [MAX_SYMBOLS];
  logic             store_nxt [MAX_SYMBOLS];

  logic [1:0] pend_cnt_r;
  mkd_out_t   res0_r, res1_r;

  logic       in_fire, out_fire;
  logic [1:0] k_nxt;
  mkd_out_t   r0_nxt, r1_nxt;

  logic             append;
  logic             sym;
  logic [7:0]       sil_inc;
  logic [TOT_W-1:0] dec_total;
  logic [CODE_W-1:0] code;
  mkd_lookup_t      lk;
  mkd_out_t         char_res;

  assign in_fire  = in_chan.valid & in_chan.ready;
  assign out_fire = out_chan.valid & out_chan.ready;

  assign in_chan.ready  = (pend_cnt_r == 2'd0) | ((pend_cnt_r == 2'd1) & out_chan.ready);
  assign out_chan.valid = (pend_cnt_r != 2'd0);
  assign out_chan.data  = res0_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_press_r  <= MIN_PRESS_RST;
      dot_limit_r  <= DOT_LIMIT_RST;
      dash_limit_r <= DASH_LIMIT_RST;
      gap_ticks_r  <= GAP_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MIN_PRESS:  min_press_r  <= cfg_wdata;
        REG_DOT_LIMIT:  dot_limit_r  <= cfg_wdata;
        REG_DASH_LIMIT: dash_limit_r <= cfg_wdata;
        REG_GAP_TICKS:  gap_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // classify and buffer
  always_comb begin
    sym     = (press_r > dot_limit_r);
    sil_inc = (silence_r == 8'hFF) ? silence_r : silence_r + 8'd1;
    append  = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (!in_chan.data.key_down && press_r != 8'd0 && press_r > min_press_r &&
        press_r <= dash_limit_r && total_r < TOT_W'(MAX_SYMBOLS)) begin
      append = 1'b1;
      store_nxt[total_r[IDX_W-1:0]] = sym;
    end
    dec_total = append ? total_r + TOT_W'(1) : total_r;
  end

  // decode the buffer
  always_comb begin
    code = CODE_W'(1);
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (TOT_W'(i) < dec_total) begin
        code = {code[CODE_W-2:0], store_nxt[i]};
      end
    end
    lk = mkd_lookup(MKD_CODE_W'(code));
    char_res.event_kind = EV_CHAR;
    char_res.last       = 1'b0;
    if (dec_total == '0) begin
      char_res.char_code  = CHAR_SPACE;
      char_res.recognized = 1'b1;
    end else begin
      char_res.char_code  = lk.ascii;
      char_res.recognized = lk.hit;
    end
  end

  // next state and results
  always_comb begin
    press_nxt   = press_r;
    silence_nxt = silence_r;
    total_nxt   = total_r;
    k_nxt       = 2'd0;
    r0_nxt      = char_res;
    r1_nxt      = char_res;
    if (in_chan.data.key_down) begin
      press_nxt   = (press_r == 8'hFF) ? press_r : press_r + 8'd1;
      silence_nxt = 8'd0;
    end else if (press_r != 8'd0) begin
      press_nxt   = 8'd0;
      silence_nxt = 8'd0;
      priority if (press_r <= min_press_r) begin
        k_nxt = 2'd0;
      end else if (press_r <= dash_limit_r) begin
        total_nxt = dec_total;
        r0_nxt    = '{event_kind: (sym ? EV_DASH : EV_DOT), char_code: 7'd0,
                      recognized: 1'b0, last: 1'b0};
        k_nxt     = 2'd1;
        if (dec_total >= TOT_W'(MAX_SYMBOLS)) begin
          total_nxt = '0;
          k_nxt     = 2'd2;
        end
      end else begin
        r0_nxt = '{event_kind: EV_LONG, char_code: 7'd0, recognized: 1'b0, last: 1'b0};
        k_nxt  = 2'd1;
      end
    end else begin
      silence_nxt = sil_inc;
      if (sil_inc >= gap_ticks_r) begin
        silence_nxt = 8'd0;
        total_nxt   = '0;
        k_nxt       = 2'd1;
      end
    end
    r0_nxt.last = (k_nxt == 2'd1);
    r1_nxt.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r    <= 8'd0;
      silence_r  <= 8'd0;
      total_r    <= '0;
      pend_cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        press_r    <= press_nxt;
        silence_r  <= silence_nxt;
        total_r    <= total_nxt;
        pend_cnt_r <= k_nxt;
      end else if (out_fire) begin
        pend_cnt_r <= pend_cnt_r - 2'd1;
      end
    end
  end

  // payload: hold, advance on transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      store_r <= store_nxt;
      res0_r  <= r0_nxt;
      res1_r  <= r1_nxt;
    end else if (out_fire) begin
      res0_r <= res1_r;
    end
  end

  `MKD_ASSERT_NOW(a_total_below_max, clk, rst_n, 1'b1, total_r < TOT_W'(MAX_SYMBOLS))
  `MKD_ASSERT_NOW(a_pend_cnt_range, clk, rst_n, 1'b1, pend_cnt_r != 2'd3)
  `MKD_ASSERT_NOW(a_head_not_last, clk, rst_n, pend_cnt_r == 2'd2, !res0_r.last)
  `MKD_ASSERT_NEXT(a_press_no_result, clk, rst_n, in_fire && in_chan.data.key_down, pend_cnt_r == 2'd0)

endmodule
